[rtl/kpe_pkg.sv]
// Shared types and constants for the k-permutation enumerator.
package kpe_pkg;

    localparam int MAX_LEN      = 6;
    localparam int SYMBOL_SLOTS = 6;
    localparam int DIGIT_W      = 3;
    localparam int SYM_W        = 8;
    localparam int COUNT_W      = 10;
    localparam int LEN_W        = 3;
    localparam int SET_W        = SYMBOL_SLOTS * SYM_W;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 64;

    localparam logic [CFG_ADDR_W-1:0] ADDR_SYMBOL_SET  = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_PERM_LENGTH = 4'h8;

    localparam logic [LEN_W-1:0] LEN_RESET = 3'd1;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [MAX_LEN-1:0] tuple_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK0,
        ST_SEEK,
        ST_FOUND,
        ST_AHEAD,
        ST_EMIT_EXH,
        ST_EMIT_LAST,
        ST_EMIT_MORE
    } state_t;

    typedef struct packed {
        logic clr_run;
        logic set_started;
        logic set_done;
        logic zero_work;
        logic load_work;
        logic step_work;
        logic commit;
        logic emit;
        logic emit_exh;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic run_started;
        logic run_done;
        logic work_valid;
        logic next_valid;
        logic next_wrap;
        logic out_busy;
    } stat_t;

endpackage

[rtl/kpe_ctrl.sv]
// Sequencer for the k-permutation enumerator: request decode, search and result issue.
module kpe_ctrl
    import kpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_restart,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clr_run = in_restart;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.run_done)
                begin
                    state_next = ST_EMIT_EXH;
                end
                else if (!stat.run_started)
                begin
                    cmd.zero_work   = 1'b1;
                    cmd.set_started = 1'b1;
                    state_next      = ST_CHECK0;
                end
                else
                begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_SEEK;
                end
            end
            ST_CHECK0:
            begin
                // the all-zero tuple is only valid for a length of one
                state_next = stat.work_valid ? ST_FOUND : ST_SEEK;
            end
            ST_SEEK:
            begin
                cmd.step_work = 1'b1;
                if (stat.next_wrap)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_EMIT_EXH;
                end
                else if (stat.next_valid)
                begin
                    state_next = ST_FOUND;
                end
            end
            ST_FOUND:
            begin
                cmd.commit = 1'b1;
                state_next = ST_AHEAD;
            end
            ST_AHEAD:
            begin
                cmd.step_work = 1'b1;
                if (stat.next_wrap)
                begin
                    state_next = ST_EMIT_LAST;
                end
                else if (stat.next_valid)
                begin
                    state_next = ST_EMIT_MORE;
                end
            end
            ST_EMIT_EXH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_exh = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_LAST:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.set_done  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_MORE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/kpe_dpath.sv]
// Datapath for the k-permutation enumerator: odometer, tuple check, run state and result register.
module kpe_dpath
    import kpe_pkg::*;
#(
    parameter int SYMBOL_COUNT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [SET_W-1:0]      symbol_set,
    input  len_t                  len,
    input  logic                  m_tready,
    output stat_t                 stat,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    tuple_t digit_reg;
    tuple_t work_reg;
    tuple_t step_digits;
    count_t total_reg;
    logic   started_reg;
    logic   done_reg;
    logic   carry;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_exh_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    function automatic logic tuple_ok(tuple_t d, len_t n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i < int'(n))
            begin
                if (int'(d[i]) >= SYMBOL_COUNT)
                begin
                    ok = 1'b0;
                end
                for (int j = 0; j < i; j++)
                begin
                    if (d[i] == d[j])
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    // One odometer step, last position fastest; carry out of position 0 means wrap.
    always_comb
    begin
        step_digits = work_reg;
        carry       = 1'b1;
        for (int k = MAX_LEN - 1; k >= 0; k--)
        begin
            if ((k < int'(len)) && carry)
            begin
                if (int'(step_digits[k]) + 1 < SYMBOL_COUNT)
                begin
                    step_digits[k] = step_digits[k] + digit_t'(1);
                    carry          = 1'b0;
                end
                else
                begin
                    step_digits[k] = '0;
                end
            end
        end
    end

    always_comb
    begin
        stat.run_started = started_reg;
        stat.run_done    = done_reg;
        stat.work_valid  = tuple_ok(work_reg, len);
        stat.next_valid  = tuple_ok(step_digits, len);
        stat.next_wrap   = carry;
        stat.out_busy    = out_valid_reg && !m_tready;
    end

    // Build the result word from the committed tuple; exhausted words carry the count only.
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (!cmd.emit_exh && (i < int'(len)) && (int'(digit_reg[i]) < SYMBOL_SLOTS))
            begin
                out_data_next[SYM_W*i +: SYM_W] = symbol_set[SYM_W*int'(digit_reg[i]) +: SYM_W];
            end
        end
        out_data_next[SET_W +: COUNT_W] = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg     <= '0;
            total_reg     <= '0;
            started_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_run)
            begin
                started_reg <= 1'b0;
                done_reg    <= 1'b0;
                total_reg   <= '0;
            end
            else
            begin
                if (cmd.set_started)
                begin
                    started_reg <= 1'b1;
                end
                if (cmd.set_done)
                begin
                    done_reg <= 1'b1;
                end
                if (cmd.commit)
                begin
                    digit_reg <= work_reg;
                    total_reg <= total_reg + count_t'(1);
                end
                else if (cmd.zero_work)
                begin
                    digit_reg <= '0;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.zero_work)
        begin
            work_reg <= '0;
        end
        else if (cmd.load_work)
        begin
            work_reg <= digit_reg;
        end
        else if (cmd.step_work)
        begin
            work_reg <= step_digits;
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.emit_last;
            out_exh_reg  <= cmd.emit_exh;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_exh_reg;

endmodule

[rtl/k_permutation_enumerator.sv]
// Top level of the k-permutation enumerator: register port, sequencer and datapath.
// The sequencer decodes a request and steps the odometer, one step per cycle, to the next valid
// tuple and on to the one after it; a run's first word adds the all-zero check. An exhausted
// word is issued straight from the decode, or after the search when the odometer wraps.
// Only one request is in flight; a result waits in the output register while the next
// request is taken. Reset: asynchronous, active low; clears the run, the tuple and the
// result valid, symbol_set to zero and perm_length to one.
module k_permutation_enumerator
    import kpe_pkg::*;
#(
    parameter int SYMBOL_COUNT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] sym_0 .. [47:40] sym_5,
                                             // [57:48] arrangement_count, [63:58] zero
    output logic                  m_tlast,   // is_final
    output logic                  m_tuser,   // [0] exhausted
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SET_W-1:0] symbol_set_reg;
    len_t             perm_length_reg;
    len_t             eff_len;
    logic             cfg_write;
    cmd_t             cmd;
    stat_t            stat;

    // Register port: zero wait states, write on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_set_reg  <= '0;
            perm_length_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_SYMBOL_SET:  symbol_set_reg  <= pwdata[SET_W-1:0];
                ADDR_PERM_LENGTH: perm_length_reg <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_SYMBOL_SET:  prdata = CFG_DATA_W'(symbol_set_reg);
            ADDR_PERM_LENGTH: prdata = CFG_DATA_W'(perm_length_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp the length: zero acts as one, seven as six.
    always_comb
    begin
        if (perm_length_reg == len_t'(0))
        begin
            eff_len = len_t'(1);
        end
        else if (int'(perm_length_reg) > MAX_LEN)
        begin
            eff_len = len_t'(MAX_LEN);
        end
        else
        begin
            eff_len = perm_length_reg;
        end
    end

    kpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    kpe_dpath #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .symbol_set (symbol_set_reg),
        .len        (eff_len),
        .m_tready   (m_tready),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // An exhausted word carries no symbols and is never the final arrangement.
    a_exhausted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata[SET_W-1:0] == '0) && !m_tlast))
        else $error("exhausted word with symbols or last flag");

    // Hold off further requests while one is being worked on.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // With a length of one, the symbols beyond the first stay zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (eff_len == len_t'(1))) |-> (m_tdata[SET_W-1:SYM_W] == '0))
        else $error("symbol beyond length is not zero");

    // After the final arrangement the run answers exhausted until a restart.
    a_final_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_last) |=> stat.run_done)
        else $error("run not closed after final arrangement");

endmodule
